### sv/pvsa_pkg.sv
// Package for the priority voice slot allocator.
// Holds command and reason codes, field widths and the channel payload structs.
// No dependencies.
package pvsa_pkg;

    // Default table size and the cap on results reported per command
    localparam int DEF_NUM_SLOTS = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int RES_CNT_W     = 6;

    // Command codes
    localparam logic [1:0] CMD_PLAY     = 2'd0;
    localparam logic [1:0] CMD_STOP     = 2'd1;
    localparam logic [1:0] CMD_FINISH   = 2'd2;
    localparam logic [1:0] CMD_SHUTDOWN = 2'd3;

    // Event reason codes
    localparam logic [2:0] RSN_FINISHED = 3'd0;
    localparam logic [2:0] RSN_STOPPED  = 3'd1;
    localparam logic [2:0] RSN_EVICTED  = 3'd2;
    localparam logic [2:0] RSN_REJECTED = 3'd3;
    localparam logic [2:0] RSN_SHUTDOWN = 3'd4;
    localparam logic [2:0] RSN_PLACED   = 3'd5;

    // Command channel payload
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] voice_handle;
        logic [7:0]  voice_priority;
    } t_cmd_item;

    // Event channel payload
    typedef struct packed {
        logic [2:0]  event_reason;
        logic [31:0] event_handle;
        logic [4:0]  event_slot;
        logic [5:0]  voices_active;
        logic        last_event;
    } t_evt_item;

    // One entry of the slot memory
    typedef struct packed {
        logic [31:0] handle;
        logic [7:0]  prio;
    } t_slot_entry;

endpackage

### sv/priority_voice_slot_allocator.sv
// Priority voice slot allocator: slot table in a synchronous memory, scanned per command.
// Depends on pvsa_pkg.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------
//  command  | in        | i_cmd_valid / o_cmd_ready    | i_cmd
//  event    | out       | o_evt_valid / i_evt_ready    | o_evt
//
// Each command reads the slots in order through the registered memory read port, one
// slot a cycle unless the event output stalls; a play stops at the first empty slot, and
// stop, finish and shutdown read every slot. Valid bits live in flip-flops and are
// cleared by reset; handles and priorities need no reset. Reset is synchronous, active
// low. A stalled event output holds the scan once its one-entry holding stage is full;
// one finished event may wait at the output while the next command is taken.
module priority_voice_slot_allocator
    import pvsa_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd_item i_cmd,
    output logic      o_evt_valid,
    input  logic      i_evt_ready,
    output t_evt_item o_evt
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int AW = SW + 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_EVICT  = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_REJECT = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    // Slot memory and its registered read data
    t_slot_entry r_mem [NUM_SLOTS];
    t_slot_entry r_rd;

    logic [2:0]           r_state, n_state;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [CW-1:0]        r_occ, n_occ;
    logic [AW-1:0]        r_ra, n_ra;
    logic                 r_dv, n_dv;
    logic [SW-1:0]        r_di, n_di;
    logic [SW-1:0]        r_tgt, n_tgt;
    logic [1:0]           r_cmd, n_cmd;
    logic [31:0]          r_handle, n_handle;
    logic [7:0]           r_prio, n_prio;
    logic [7:0]           r_lo_prio, n_lo_prio;
    logic [31:0]          r_lo_handle, n_lo_handle;
    logic [SW-1:0]        r_lo_idx, n_lo_idx;
    logic [RES_CNT_W-1:0] r_nres, n_nres;

    t_evt_item r_pend, r_out, emit_ev, out_ev;
    logic      r_pend_v, r_out_v;

    logic rd_en, mem_we, emit_v, emit_store, pend_move, out_free, adv, last_slot;

    assign out_free    = !r_out_v || i_evt_ready;
    assign adv         = !r_pend_v || out_free;
    assign last_slot   = (r_di == SW'(NUM_SLOTS - 1));
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_evt_valid = r_out_v;
    assign o_evt       = r_out;

    // Sequencer: scan, decide, write back
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_occ       = r_occ;
        n_ra        = r_ra;
        n_dv        = r_dv;
        n_di        = r_di;
        n_tgt       = r_tgt;
        n_cmd       = r_cmd;
        n_handle    = r_handle;
        n_prio      = r_prio;
        n_lo_prio   = r_lo_prio;
        n_lo_handle = r_lo_handle;
        n_lo_idx    = r_lo_idx;
        rd_en       = 1'b0;
        mem_we      = 1'b0;
        emit_v      = 1'b0;
        emit_ev     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd.command;
                    n_handle = i_cmd.voice_handle;
                    n_prio   = i_cmd.voice_priority;
                    n_ra     = '0;
                    n_dv     = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (adv) begin
                    rd_en = (r_ra < AW'(NUM_SLOTS));
                    n_ra  = rd_en ? r_ra + AW'(1) : r_ra;
                    n_dv  = rd_en;
                    n_di  = r_ra[SW-1:0];
                    if (r_dv) begin
                        if (r_cmd == CMD_PLAY) begin
                            if (!r_valid[r_di]) begin
                                // first empty slot wins; drop the read in flight
                                n_tgt   = r_di;
                                n_dv    = 1'b0;
                                n_state = S_PLACE;
                            end else begin
                                if (r_di == '0 || r_rd.prio < r_lo_prio) begin
                                    n_lo_prio   = r_rd.prio;
                                    n_lo_handle = r_rd.handle;
                                    n_lo_idx    = r_di;
                                end
                                if (last_slot) begin
                                    n_state = S_DECIDE;
                                end
                            end
                        end else begin
                            if (r_valid[r_di] &&
                                (r_cmd == CMD_SHUTDOWN || r_rd.handle == r_handle)) begin
                                n_valid[r_di] = 1'b0;
                                n_occ         = r_occ - CW'(1);
                                emit_v        = 1'b1;
                                if (r_cmd == CMD_SHUTDOWN) begin
                                    emit_ev.event_reason = RSN_SHUTDOWN;
                                end else if (r_cmd == CMD_STOP) begin
                                    emit_ev.event_reason = RSN_STOPPED;
                                end else begin
                                    emit_ev.event_reason = RSN_FINISHED;
                                end
                                emit_ev.event_handle  = r_rd.handle;
                                emit_ev.event_slot    = 5'(r_di);
                                emit_ev.voices_active = 6'(n_occ);
                            end
                            if (last_slot) begin
                                n_state = S_FLUSH;
                            end
                        end
                    end
                end
            end
            S_DECIDE: begin
                n_state = (r_prio > r_lo_prio) ? S_EVICT : S_REJECT;
            end
            S_EVICT: begin
                if (adv) begin
                    n_valid[r_lo_idx]     = 1'b0;
                    n_occ                 = r_occ - CW'(1);
                    emit_v                = 1'b1;
                    emit_ev.event_reason  = RSN_EVICTED;
                    emit_ev.event_handle  = r_lo_handle;
                    emit_ev.event_slot    = 5'(r_lo_idx);
                    emit_ev.voices_active = 6'(n_occ);
                    n_tgt                 = r_lo_idx;
                    n_state               = S_PLACE;
                end
            end
            S_PLACE: begin
                if (adv) begin
                    n_valid[r_tgt]        = 1'b1;
                    n_occ                 = r_occ + CW'(1);
                    mem_we                = 1'b1;
                    emit_v                = 1'b1;
                    emit_ev.event_reason  = RSN_PLACED;
                    emit_ev.event_handle  = r_handle;
                    emit_ev.event_slot    = 5'(r_tgt);
                    emit_ev.voices_active = 6'(n_occ);
                    n_state               = S_FLUSH;
                end
            end
            S_REJECT: begin
                if (adv) begin
                    emit_v                = 1'b1;
                    emit_ev.event_reason  = RSN_REJECTED;
                    emit_ev.event_handle  = r_handle;
                    emit_ev.event_slot    = '0;
                    emit_ev.voices_active = 6'(r_occ);
                    n_state               = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Results past the cap are dropped; the held one moves out on the next event or flush
    assign emit_store = emit_v && (r_nres < RES_CNT_W'(MAX_RESULTS));
    assign pend_move  = r_pend_v && out_free && (emit_store || r_state == S_FLUSH);

    always_comb begin
        n_nres = r_nres;
        if (r_state == S_IDLE) begin
            n_nres = '0;
        end else if (emit_store) begin
            n_nres = r_nres + RES_CNT_W'(1);
        end
    end

    // Held event on its way out; the flush marks it as the last of the command
    always_comb begin
        out_ev            = r_pend;
        out_ev.last_event = (r_state == S_FLUSH);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_occ    <= '0;
            r_dv     <= 1'b0;
            r_nres   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_dv    <= n_dv;
            r_nres  <= n_nres;
            if (emit_store) begin
                r_pend_v <= 1'b1;
            end else if (pend_move) begin
                r_pend_v <= 1'b0;
            end
            if (pend_move) begin
                r_out_v <= 1'b1;
            end else if (i_evt_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ra        <= n_ra;
        r_di        <= n_di;
        r_tgt       <= n_tgt;
        r_cmd       <= n_cmd;
        r_handle    <= n_handle;
        r_prio      <= n_prio;
        r_lo_prio   <= n_lo_prio;
        r_lo_handle <= n_lo_handle;
        r_lo_idx    <= n_lo_idx;
        if (emit_store) begin
            r_pend <= emit_ev;
        end
        if (pend_move) begin
            r_out <= out_ev;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tgt] <= '{handle: r_handle, prio: r_prio};
        end
        if (rd_en) begin
            r_rd <= r_mem[r_ra[SW-1:0]];
        end
    end

`ifndef NO_ASSERTIONS
    // Occupancy count tracks the valid bits
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == CW'($countones(r_valid)))
        else $error("occupancy count out of step with valid bits");

    // Nothing is held back once a new command can be taken
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> !r_pend_v)
        else $error("held event left behind at end of command");

    // A command transfer starts a scan from slot zero
    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && o_cmd_ready |=> r_state == S_SCAN && r_ra == '0 && !r_dv)
        else $error("scan did not start after command transfer");

    // Events never exceed the per-command cap
    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RES_CNT_W'(MAX_RESULTS))
        else $error("result count past cap");

    // An event is only written into the held stage when the stage can drain
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_store && r_pend_v |-> pend_move)
        else $error("held event overwritten");
`endif

endmodule

### sim/priority_voice_slot_allocator_tb.sv
// Testbench for priority_voice_slot_allocator: drives commands, predicts events, checks them.
// Depends on pvsa_pkg and the priority_voice_slot_allocator RTL.
// The predictor keeps its own slot table and compares each event transfer field by field.
module priority_voice_slot_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pvsa_pkg::*;

    localparam int SLOTS        = DEF_NUM_SLOTS;
    localparam int QUIET_LIMIT  = 4000;   // cycles with no transfer before giving up
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 100;    // a scan plus margin

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cmd_valid;
    logic      o_cmd_ready;
    t_cmd_item i_cmd;
    logic      o_evt_valid;
    logic      i_evt_ready;
    t_evt_item o_evt;

    // Predicted slot table
    bit        slot_live [SLOTS];
    bit [31:0] slot_hdl  [SLOTS];
    bit [7:0]  slot_pri  [SLOTS];
    int        live_count;

    t_evt_item awaited_events[$];
    int        err_count   = 0;
    bit        gaps_on     = 1'b1;
    bit        stalls_on   = 1'b1;
    int        hold_cycles = 0;

    priority_voice_slot_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(i_cmd_valid),
        .o_cmd_ready(o_cmd_ready),
        .i_cmd      (i_cmd),
        .o_evt_valid(o_evt_valid),
        .i_evt_ready(i_evt_ready),
        .o_evt      (o_evt)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Append one expected event at the tail of the queue
    function automatic void add_awaited(input t_evt_item ev);
        awaited_events.insert(awaited_events.size(), ev);
    endfunction

    // Event bookkeeping: one event is held back so the last one can get its flag
    function automatic void queue_event(inout t_evt_item held, inout bit have_held,
                                        inout int n, input logic [2:0] reason,
                                        input bit [31:0] hdl, input int slot);
        if (n >= MAX_RESULTS) return;
        if (have_held) add_awaited(held);
        held.event_reason  = reason;
        held.event_handle  = hdl;
        held.event_slot    = 5'(slot);
        held.voices_active = 6'(live_count);
        held.last_event    = 1'b0;
        have_held          = 1'b1;
        n++;
    endfunction

    function automatic void vacate_slot(inout t_evt_item held, inout bit have_held,
                                        inout int n, input int s, input logic [2:0] reason);
        slot_live[s] = 1'b0;
        if (live_count > 0) live_count--;
        queue_event(held, have_held, n, reason, slot_hdl[s], s);
    endfunction

    // Table update and expected events for one accepted command
    function automatic void predict_voice_events(input t_cmd_item c);
        t_evt_item held;
        bit        have_held;
        int        n;
        int        target;
        int        lowest;
        held      = '0;
        have_held = 1'b0;
        n         = 0;
        target    = -1;
        lowest    = 0;
        case (c.command)
            CMD_PLAY: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!slot_live[s]) begin
                        target = s;
                        break;
                    end
                    if (slot_pri[s] < slot_pri[lowest]) lowest = s;
                end
                // full table: steal only on strictly higher priority
                if (target < 0 && c.voice_priority > slot_pri[lowest]) begin
                    vacate_slot(held, have_held, n, lowest, RSN_EVICTED);
                    target = lowest;
                end
                if (target >= 0) begin
                    slot_live[target] = 1'b1;
                    slot_hdl[target]  = c.voice_handle;
                    slot_pri[target]  = c.voice_priority;
                    live_count++;
                    queue_event(held, have_held, n, RSN_PLACED, c.voice_handle, target);
                end else begin
                    queue_event(held, have_held, n, RSN_REJECTED, c.voice_handle, 0);
                end
            end
            CMD_STOP, CMD_FINISH: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_live[s] && slot_hdl[s] == c.voice_handle) begin
                        vacate_slot(held, have_held, n, s,
                                    (c.command == CMD_STOP) ? RSN_STOPPED : RSN_FINISHED);
                    end
                end
            end
            default: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_live[s]) vacate_slot(held, have_held, n, s, RSN_SHUTDOWN);
                end
            end
        endcase
        if (have_held) begin
            held.last_event = 1'b1;
            add_awaited(held);
        end
    endfunction

    function automatic void report_mismatch(input string field, input logic [31:0] want,
                                            input logic [31:0] got);
        err_count++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                 $time, field, want, got);
    endfunction

    // Checker: every event transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_evt_item want;
        if (i_rst_n && o_evt_valid && i_evt_ready) begin
            if (awaited_events.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected event, expected none, %s %0d handle %0h slot %0d",
                         $time, "actual reason", o_evt.event_reason, o_evt.event_handle,
                         o_evt.event_slot);
            end else begin
                want = awaited_events.pop_front();
                if (o_evt.event_reason !== want.event_reason)
                    report_mismatch("event_reason", 32'(want.event_reason),
                                    32'(o_evt.event_reason));
                if (o_evt.event_handle !== want.event_handle)
                    report_mismatch("event_handle", want.event_handle, o_evt.event_handle);
                if (o_evt.event_slot !== want.event_slot)
                    report_mismatch("event_slot", 32'(want.event_slot), 32'(o_evt.event_slot));
                if (o_evt.voices_active !== want.voices_active)
                    report_mismatch("voices_active", 32'(want.voices_active),
                                    32'(o_evt.voices_active));
                if (o_evt.last_event !== want.last_event)
                    report_mismatch("last_event", 32'(want.last_event), 32'(o_evt.last_event));
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_cycles > 0) begin
                i_evt_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                i_evt_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_evt_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_cmd_valid && o_cmd_ready) || (o_evt_valid && i_evt_ready)) quiet = 0;
            else quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // One command transfer; the table prediction happens at the accepting edge
    task automatic send_cmd(input t_cmd_item c);
        i_cmd_valid <= 1'b1;
        i_cmd       <= c;
        @(posedge i_clk);
        while (!o_cmd_ready) @(posedge i_clk);
        predict_voice_events(c);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            i_cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    function automatic t_cmd_item make_cmd(input logic [1:0] cmd, input logic [31:0] hdl,
                                           input logic [7:0] pri);
        t_cmd_item c;
        c.command        = cmd;
        c.voice_handle   = hdl;
        c.voice_priority = pri;
        return c;
    endfunction

    // Handle of some occupied slot, random if the table is empty
    function automatic logic [31:0] live_handle();
        int start;
        int s;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            s = (start + k) % SLOTS;
            if (slot_live[s]) return slot_hdl[s];
        end
        return $urandom;
    endfunction

    // Mostly plays, with small handle and priority pools for duplicates and ties
    function automatic t_cmd_item random_cmd();
        t_cmd_item c;
        int        pick;
        pick             = $urandom_range(0, 99);
        c.voice_handle   = $urandom;
        c.voice_priority = 8'($urandom_range(0, 255));
        if (pick < 4 && (live_count >= SLOTS - 8 || pick == 0)) begin
            c.command = CMD_SHUTDOWN;
        end else if (pick < 26) begin
            c.command = $urandom_range(0, 1) ? CMD_STOP : CMD_FINISH;
            if (pick < 21 && live_count > 0) c.voice_handle = live_handle();
        end else begin
            c.command = CMD_PLAY;
            if ($urandom_range(0, 3) == 0) c.voice_handle = $urandom_range(0, 7);
            if ($urandom_range(0, 2) == 0) c.voice_priority = 8'($urandom_range(0, 3));
        end
        return c;
    endfunction

    // Empty table, extreme fields, duplicates, no-match and commands after shutdown
    task automatic test_empty_table_cases();
        send_cmd(make_cmd(CMD_STOP, 32'h0, 8'hFF));
        send_cmd(make_cmd(CMD_FINISH, 32'hFFFF_FFFF, 8'h00));
        send_cmd(make_cmd(CMD_SHUTDOWN, 32'h0, 8'h00));
        send_cmd(make_cmd(CMD_PLAY, 32'h0, 8'h00));
        send_cmd(make_cmd(CMD_PLAY, 32'hFFFF_FFFF, 8'hFF));
        send_cmd(make_cmd(CMD_PLAY, 32'h0, 8'h80));
        send_cmd(make_cmd(CMD_PLAY, 32'h5A5A_5A5A, 8'h7F));
        send_cmd(make_cmd(CMD_STOP, 32'hA5A5_A5A5, 8'h00));
        send_cmd(make_cmd(CMD_FINISH, 32'h0, 8'h00));
        send_cmd(make_cmd(CMD_STOP, 32'hFFFF_FFFF, 8'hFF));
        send_cmd(make_cmd(CMD_SHUTDOWN, 32'hFFFF_FFFF, 8'hFF));
        send_cmd(make_cmd(CMD_PLAY, 32'h1234_5678, 8'h01));
    endtask

    // Full table: rejection on lower or equal priority, stealing the first lowest slot
    task automatic test_full_table_stealing();
        if (live_count != 0)
            send_cmd(make_cmd(CMD_SHUTDOWN, $urandom, 8'($urandom_range(0, 255))));
        for (int i = 0; i < SLOTS; i++) begin
            send_cmd(make_cmd(CMD_PLAY, (i == 20) ? slot_hdl[7] : $urandom,
                              (i == 11 || i == 25) ? 8'd5 : 8'($urandom_range(20, 255))));
        end
        send_cmd(make_cmd(CMD_PLAY, $urandom, 8'd5));
        send_cmd(make_cmd(CMD_PLAY, $urandom, 8'd0));
        send_cmd(make_cmd(CMD_PLAY, 32'hFFFF_FFFF, 8'd6));
        send_cmd(make_cmd(CMD_PLAY, 32'h0, 8'd255));
        send_cmd(make_cmd(CMD_STOP, slot_hdl[7], 8'd0));
        send_cmd(make_cmd(CMD_FINISH, slot_hdl[3], 8'd0));
        while (live_count < SLOTS)
            send_cmd(make_cmd(CMD_PLAY, $urandom, 8'($urandom_range(0, 255))));
        send_cmd(make_cmd(CMD_PLAY, $urandom, 8'd255));
        send_cmd(make_cmd(CMD_SHUTDOWN, $urandom, 8'($urandom_range(0, 255))));
    endtask

    task automatic test_random_commands();
        repeat (20) send_cmd(random_cmd());
    endtask

    // Receiver holds off while commands keep coming, so the input side stalls
    task automatic test_event_backpressure();
        hold_cycles = HOLD_CYCLES;
        repeat (12) send_cmd(make_cmd(CMD_PLAY, $urandom, 8'($urandom_range(0, 255))));
        send_cmd(make_cmd(CMD_SHUTDOWN, $urandom, 8'($urandom_range(0, 255))));
    endtask

    task automatic test_steady_stream();
        repeat (20) send_cmd(random_cmd());
    endtask

    // Sequence of tests
    initial begin
        i_rst_n     <= 1'b0;
        i_cmd_valid <= 1'b0;
        i_cmd       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table_cases();
        test_full_table_stealing();
        test_random_commands();
        test_event_backpressure();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_steady_stream();
        i_cmd_valid <= 1'b0;

        while (awaited_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && awaited_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/pvsa_pkg.sv
sv/priority_voice_slot_allocator.sv
sim/priority_voice_slot_allocator_tb.sv
